FILE: src/tmtw_pkg.sv
// Shared constants, types and address helpers for the text-mode terminal writer.
`default_nettype none

package tmtw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

    localparam int COL_W  = (SCREEN_COLUMNS > 2) ? $clog2(SCREEN_COLUMNS) : 1;
    localparam int ROW_W  = (SCREEN_ROWS > 2) ? $clog2(SCREEN_ROWS) : 1;
    localparam int ADDR_W = $clog2(CELL_COUNT);

    localparam int MODE_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int IN_COL_W   = 7;
    localparam int IN_ROW_W   = 5;
    localparam int CELL_W     = CHAR_W + COLOR_W;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POKE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;

    typedef enum logic [3:0] {
        S_INIT = 4'b0001,
        S_IDLE = 4'b0010,
        S_FILL = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // Map a screen row to its place in the store, given the current top row.
    function automatic row_t phys_row(input row_t lrow, input row_t top);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= (ROW_W + 1)'(SCREEN_ROWS))
        begin
            sum = sum - (ROW_W + 1)'(SCREEN_ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic addr_t cell_addr(input row_t prow, input col_t col);
        return ADDR_W'(prow) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

FILE: src/tmtw_req_if.sv
// Request channel: one command word per handshake.
`default_nettype none

interface tmtw_req_if;
    logic                            valid;
    logic                            ready;
    logic [tmtw_pkg::MODE_W-1:0]     mode;
    logic [tmtw_pkg::CHAR_W-1:0]     char_code;
    logic [tmtw_pkg::COLOR_W-1:0]    cell_color;
    logic [tmtw_pkg::IN_COL_W-1:0]   cell_column;
    logic [tmtw_pkg::IN_ROW_W-1:0]   cell_row;

    modport source (output valid, mode, char_code, cell_color, cell_column, cell_row,
                    input ready);
    modport sink   (input valid, mode, char_code, cell_color, cell_column, cell_row,
                    output ready);
endinterface

`default_nettype wire

FILE: src/tmtw_rsp_if.sv
// Response channel: one result word per handshake.
`default_nettype none

interface tmtw_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [tmtw_pkg::CELL_W-1:0]     read_cell;
    logic [tmtw_pkg::IN_COL_W-1:0]   cursor_column_out;
    logic [tmtw_pkg::IN_ROW_W-1:0]   cursor_row_out;

    modport source (output valid, read_cell, cursor_column_out, cursor_row_out,
                    input ready);
    modport sink   (input valid, read_cell, cursor_column_out, cursor_row_out,
                    output ready);
endinterface

`default_nettype wire

FILE: src/text_mode_terminal_writer_unit.sv
// Text-mode terminal writer: screen store, cursor and scroll/clear sequencer.
//
//   channel   dir   word
//   req       in    mode, char_code, cell_color, cell_column, cell_row
//   rsp       out   read_cell, cursor_column_out, cursor_row_out
//   cfg       in    cfg_we, cfg_wdata (text_color)
//
// Put, poke and peek go from IDLE to DONE; a put that scrolls first blanks SCREEN_COLUMNS
// cells in FILL, clear blanks every cell there: the screen RAM blanks one cell a cycle.
// Scroll moves a top-row offset and blanks only the row that comes into view.
// After reset a blanking pass over every cell runs before req.ready.
// A held rsp result does not stop acceptance; it stalls the next result and req.ready with it.
`default_nettype none

module text_mode_terminal_writer_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    tmtw_req_if.sink                            req,
    tmtw_rsp_if.source                          rsp,
    input  wire logic                           cfg_we,
    input  wire logic [tmtw_pkg::COLOR_W-1:0]   cfg_wdata
);

    tmtw_pkg::cell_t   mem [tmtw_pkg::CELL_COUNT];
    tmtw_pkg::cell_t   rd_data_reg;

    tmtw_pkg::state_t  state_reg, state_next;
    tmtw_pkg::col_t    cur_col_reg, cur_col_next;
    tmtw_pkg::row_t    cur_row_reg, cur_row_next;
    tmtw_pkg::row_t    top_reg, top_next;
    tmtw_pkg::addr_t   fill_addr_reg, fill_addr_next;
    tmtw_pkg::addr_t   fill_end_reg, fill_end_next;
    logic [tmtw_pkg::COLOR_W-1:0] fill_color_reg, fill_color_next;
    logic [tmtw_pkg::COLOR_W-1:0] text_color_reg;
    logic              peek_hit_reg, peek_hit_next;

    logic              out_valid_reg, out_valid_next;
    tmtw_pkg::cell_t   out_cell_reg, out_cell_next;
    logic [tmtw_pkg::IN_COL_W-1:0] out_col_reg, out_col_next;
    logic [tmtw_pkg::IN_ROW_W-1:0] out_row_reg, out_row_next;

    logic              mem_we;
    tmtw_pkg::addr_t   mem_waddr;
    tmtw_pkg::cell_t   mem_wdata;
    logic              mem_re;
    tmtw_pkg::addr_t   mem_raddr;

    logic              accept;
    logic              in_range;
    logic              last_col;
    logic              last_row;
    tmtw_pkg::row_t    in_prow;
    tmtw_pkg::row_t    cur_prow;
    tmtw_pkg::addr_t   top_base;

    assign req.ready     = (state_reg == tmtw_pkg::S_IDLE);
    assign accept        = req.valid && req.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_cell = out_cell_reg;
    assign rsp.cursor_column_out = out_col_reg;
    assign rsp.cursor_row_out    = out_row_reg;

    assign in_range = (int'(req.cell_column) < tmtw_pkg::SCREEN_COLUMNS)
                   && (int'(req.cell_row) < tmtw_pkg::SCREEN_ROWS);
    assign last_col = (cur_col_reg == tmtw_pkg::COL_W'(tmtw_pkg::SCREEN_COLUMNS - 1));
    assign last_row = (cur_row_reg == tmtw_pkg::ROW_W'(tmtw_pkg::SCREEN_ROWS - 1));
    assign in_prow  = tmtw_pkg::phys_row(tmtw_pkg::ROW_W'(req.cell_row), top_reg);
    assign cur_prow = tmtw_pkg::phys_row(cur_row_reg, top_reg);
    assign top_base = tmtw_pkg::cell_addr(top_reg, '0);

    always_comb
    begin
        state_next      = state_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        top_next        = top_reg;
        fill_addr_next  = fill_addr_reg;
        fill_end_next   = fill_end_reg;
        fill_color_next = fill_color_reg;
        peek_hit_next   = peek_hit_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_cell_next   = out_cell_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        mem_we          = 1'b0;
        mem_waddr       = fill_addr_reg;
        mem_wdata       = {fill_color_reg, tmtw_pkg::BLANK_CHAR};
        mem_re          = 1'b0;
        mem_raddr       = tmtw_pkg::cell_addr(in_prow, tmtw_pkg::COL_W'(req.cell_column));

        case (state_reg)
            tmtw_pkg::S_INIT, tmtw_pkg::S_FILL:
            begin
                mem_we = 1'b1;
                fill_addr_next = fill_addr_reg + tmtw_pkg::ADDR_W'(1);
                if (fill_addr_reg == fill_end_reg)
                begin
                    state_next = (state_reg == tmtw_pkg::S_INIT) ? tmtw_pkg::S_IDLE
                                                                 : tmtw_pkg::S_DONE;
                end
            end
            tmtw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next    = tmtw_pkg::S_DONE;
                    peek_hit_next = 1'b0;
                    case (req.mode)
                        tmtw_pkg::MODE_PUT:
                        begin
                            if (req.char_code != tmtw_pkg::NEWLINE_CODE)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = tmtw_pkg::cell_addr(cur_prow, cur_col_reg);
                                mem_wdata = {text_color_reg, req.char_code};
                            end
                            if (req.char_code == tmtw_pkg::NEWLINE_CODE || last_col)
                            begin
                                cur_col_next = '0;
                                if (last_row)
                                begin
                                    // advance the top row and blank the row that was on top
                                    top_next = last_row && (top_reg ==
                                        tmtw_pkg::ROW_W'(tmtw_pkg::SCREEN_ROWS - 1))
                                        ? '0 : top_reg + tmtw_pkg::ROW_W'(1);
                                    fill_addr_next  = top_base;
                                    fill_end_next   = top_base
                                        + tmtw_pkg::ADDR_W'(tmtw_pkg::SCREEN_COLUMNS - 1);
                                    fill_color_next = text_color_reg;
                                    state_next      = tmtw_pkg::S_FILL;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + tmtw_pkg::ROW_W'(1);
                                end
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + tmtw_pkg::COL_W'(1);
                            end
                        end
                        tmtw_pkg::MODE_POKE:
                        begin
                            if (in_range)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = mem_raddr;
                                mem_wdata = {req.cell_color, req.char_code};
                            end
                        end
                        tmtw_pkg::MODE_PEEK:
                        begin
                            mem_re        = in_range;
                            peek_hit_next = in_range;
                        end
                        tmtw_pkg::MODE_CLEAR:
                        begin
                            cur_col_next    = '0;
                            cur_row_next    = '0;
                            top_next        = '0;
                            fill_addr_next  = '0;
                            fill_end_next   = tmtw_pkg::ADDR_W'(tmtw_pkg::CELL_COUNT - 1);
                            fill_color_next = text_color_reg;
                            state_next      = tmtw_pkg::S_FILL;
                        end
                        default:
                        begin
                            state_next = tmtw_pkg::S_DONE;
                        end
                    endcase
                end
            end
            tmtw_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = peek_hit_reg ? rd_data_reg : '0;
                    out_col_next   = tmtw_pkg::IN_COL_W'(cur_col_reg);
                    out_row_next   = tmtw_pkg::IN_ROW_W'(cur_row_reg);
                    state_next     = tmtw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tmtw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tmtw_pkg::S_INIT;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            top_reg        <= '0;
            fill_addr_reg  <= '0;
            fill_end_reg   <= tmtw_pkg::ADDR_W'(tmtw_pkg::CELL_COUNT - 1);
            fill_color_reg <= tmtw_pkg::RESET_COLOR;
            text_color_reg <= tmtw_pkg::RESET_COLOR;
            peek_hit_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            top_reg        <= top_next;
            fill_addr_reg  <= fill_addr_next;
            fill_end_reg   <= fill_end_next;
            fill_color_reg <= fill_color_next;
            peek_hit_reg   <= peek_hit_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                text_color_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_cell_reg <= out_cell_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
    end

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(cur_col_reg) < tmtw_pkg::SCREEN_COLUMNS)
        && (int'(cur_row_reg) < tmtw_pkg::SCREEN_ROWS))
        else $error("cursor left the screen");

    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(top_reg) < tmtw_pkg::SCREEN_ROWS)
        else $error("top row offset out of range");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmtw_pkg::S_FILL || state_reg == tmtw_pkg::S_INIT)
        |-> (fill_addr_reg <= fill_end_reg)
        && (int'(fill_end_reg) < tmtw_pkg::CELL_COUNT))
        else $error("blanking pass overran its range");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("second word taken before the first completed");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

endmodule

`default_nettype wire
